[src/acedm_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, codes and types of the arithmetic encoder.
package acedm_pkg;

   localparam int SYMBOL_COUNT_DEF    = 256;
   localparam int COUNT_WIDTH_DEF     = 32;
   localparam int SCALE_LIMIT_DEF     = 16383;
   localparam int UNDERFLOW_LIMIT_DEF = 256;
   localparam int MAX_RESULTS         = 40;
   localparam int QUEUE_DEPTH         = 2;
   localparam int SCALE_BITS          = 14;
   localparam int CODE_BITS           = 16;
   localparam int DIVIDEND_BITS       = 31;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_SAT   = 2'd2;

   typedef enum logic [1:0] {
      OP_COUNT  = 2'd0,
      OP_ENCODE = 2'd1,
      OP_FINISH = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] symbol;
      logic       in_range;
   } item_type;

   typedef struct packed {
      logic                     start;
      logic [DIVIDEND_BITS-1:0] dividend;
      logic [SCALE_BITS-1:0]    divisor;
   } div_req_type;

   typedef struct packed {
      logic                     busy;
      logic                     done;
      logic [DIVIDEND_BITS-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_FETCH,
      ST_CNT_WR,
      ST_RD_RESP,
      ST_ENC_CHK,
      ST_ERR,
      ST_MUL_HI,
      ST_DIV_HI,
      ST_MUL_LO,
      ST_DIV_LO,
      ST_NORM,
      ST_PEND,
      ST_DEC,
      ST_FIN1,
      ST_FIN2,
      ST_FIN_PAD,
      ST_TAIL,
      ST_SAT,
      ST_RB_SUM,
      ST_RB_WR
   } eng_state_type;

endpackage

[src/acedm_front.sv]
`timescale 1ns / 1ps
// Request front end: decodes requests and queues them for the engine.
module acedm_front
   import acedm_pkg::*;
#(
   parameter int SYMBOL_COUNT = SYMBOL_COUNT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_symbol,
   output logic       q_valid,
   output item_type   q_item,
   input  logic       q_pop
);

   localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   item_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               push;
   item_type           new_item;

   assign req_stall = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (fill_ff != '0);
   assign q_item    = slot_ff[rd_ptr_ff];

   always_comb begin
      new_item.op       = op_type'(req_kind);
      new_item.symbol   = req_symbol;
      new_item.in_range = ({1'b0, req_symbol} < 9'(SYMBOL_COUNT));
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff + FILL_W'(push) - FILL_W'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

[src/acedm_div.sv]
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module acedm_div
   import acedm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int STEP_W = $clog2(DIVIDEND_BITS + 1);

   logic [STEP_W-1:0]        step_ff, step_in;
   logic [SCALE_BITS-1:0]    rem_ff, rem_in;
   logic [SCALE_BITS-1:0]    dvs_ff, dvs_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [SCALE_BITS:0]      trial;
   logic [SCALE_BITS:0]      diff;
   logic                     fits;

   assign trial = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_comb begin
      step_in = step_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         step_in = STEP_W'(DIVIDEND_BITS);
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         quo_in  = div_req.dividend;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[SCALE_BITS-1:0] : trial[SCALE_BITS-1:0];
         quo_in  = {quo_ff[DIVIDEND_BITS-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quo_ff  <= quo_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

[src/acedm_back.sv]
`timescale 1ns / 1ps
// Coding engine: histogram, model rebuild, interval coder and bit packer.
module acedm_back
   import acedm_pkg::*;
#(
   parameter int SYMBOL_COUNT    = SYMBOL_COUNT_DEF,
   parameter int COUNT_WIDTH     = COUNT_WIDTH_DEF,
   parameter int SCALE_LIMIT     = SCALE_LIMIT_DEF,
   parameter int UNDERFLOW_LIMIT = UNDERFLOW_LIMIT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  item_type    q_item,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic [31:0] rsp_count_value,
   output logic        rsp_last,
   output logic [1:0]  rsp_status
);

   localparam int AW = $clog2(SYMBOL_COUNT);
   localparam int IW = AW + 1;
   localparam int SW = COUNT_WIDTH + AW;
   localparam int KW = $clog2(COUNT_WIDTH + 2);
   localparam int PW = $clog2(UNDERFLOW_LIMIT + 1);
   localparam int NW = $clog2(MAX_RESULTS);
   localparam int MW = 2 * SCALE_BITS;

   eng_state_type           state_ff, state_in;
   item_type                item_ff, item_in;

   logic [COUNT_WIDTH-1:0]  cnt_mem [SYMBOL_COUNT];
   logic [MW-1:0]           mdl_mem [SYMBOL_COUNT];
   logic [COUNT_WIDTH-1:0]  cnt_rd_ff;
   logic                    cnt_vld_rd_ff;
   logic [MW-1:0]           mdl_rd_ff;
   logic [SYMBOL_COUNT-1:0] cnt_vld_ff, cnt_vld_in;
   logic                    cnt_we;
   logic [AW-1:0]           cnt_wa;
   logic [COUNT_WIDTH-1:0]  cnt_wd;
   logic                    mdl_we;
   logic [AW-1:0]           mdl_wa;
   logic [MW-1:0]           mdl_wd;

   logic [CODE_BITS-1:0]    low_ff, low_in;
   logic [CODE_BITS-1:0]    high_ff, high_in;
   logic [CODE_BITS-1:0]    hi_w_ff, hi_w_in;
   logic [CODE_BITS-1:0]    lo_w_ff, lo_w_in;
   logic [PW-1:0]           pending_ff, pending_in;
   logic [7:0]              partial_ff, partial_in;
   logic [2:0]              bitpos_ff, bitpos_in;
   logic                    hold_vld_ff, hold_vld_in;
   logic [7:0]              hold_byte_ff, hold_byte_in;
   logic [NW-1:0]           n_ff, n_in;
   logic                    sat_ff, sat_in;
   logic                    pend_bit_ff, pend_bit_in;
   logic                    model_ready_ff, model_ready_in;
   logic [SCALE_BITS-1:0]   total_ff, total_in;
   logic                    rb_post_ff, rb_post_in;
   logic [KW-1:0]           k_ff, k_in;
   logic [SW-1:0]           sum_ff, sum_in;
   logic [SCALE_BITS-1:0]   acc_ff, acc_in;
   logic [IW-1:0]           sw_idx_ff, sw_idx_in;
   logic                    sw_dv_ff, sw_dv_in;
   logic [AW-1:0]           sw_didx_ff, sw_didx_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [7:0]              rsp_byte_ff, rsp_byte_in;
   logic [31:0]             rsp_count_ff, rsp_count_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic [1:0]              rsp_status_ff, rsp_status_in;

   div_req_type             div_req;
   div_rsp_type             div_rsp;

   logic                    out_free;
   logic [AW-1:0]           sym_idx;
   logic [AW-1:0]           rd_addr;
   logic                    rb_state;
   logic [COUNT_WIDTH-1:0]  cnt_eff;
   logic [SCALE_BITS-1:0]   mdl_cum;
   logic [SCALE_BITS-1:0]   mdl_scaled;
   logic [SCALE_BITS-1:0]   cum_hi;
   logic [SCALE_BITS-1:0]   mul_cum;
   logic [CODE_BITS-1:0]    span;
   logic [CODE_BITS:0]      range;
   logic                    sw_issue;
   logic                    sw_end;
   logic [COUNT_WIDTH-1:0]  shifted;
   logic [COUNT_WIDTH-1:0]  fval;
   logic                    norm_eq;
   logic                    norm_uf;
   logic [CODE_BITS-1:0]    hi_adj;
   logic [CODE_BITS-1:0]    lo_adj;
   logic                    push_en;
   logic                    push_val;
   logic                    push_go;
   logic [7:0]              pack_byte;
   logic [7:0]              pad_byte;
   logic                    emit_en;
   logic [7:0]              emit_data;
   logic                    emit_keep;
   logic                    step_ok;
   logic                    enc_ok;

   // shared decode
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign sym_idx    = item_ff.symbol[AW-1:0];
   assign rb_state   = (state_ff == ST_RB_SUM) || (state_ff == ST_RB_WR);
   assign rd_addr    = rb_state ? sw_idx_ff[AW-1:0] : sym_idx;
   assign cnt_eff    = cnt_vld_rd_ff ? cnt_rd_ff : '0;
   assign mdl_cum    = mdl_rd_ff[MW-1:SCALE_BITS];
   assign mdl_scaled = mdl_rd_ff[SCALE_BITS-1:0];
   assign cum_hi     = mdl_cum + mdl_scaled;
   assign mul_cum    = (state_ff == ST_MUL_HI) ? cum_hi : mdl_cum;
   assign span       = high_ff - low_ff;
   assign range      = {1'b0, span} + (CODE_BITS+1)'(1);
   assign sw_issue   = (sw_idx_ff < IW'(SYMBOL_COUNT));
   assign sw_end     = !sw_issue && !sw_dv_ff;
   assign shifted    = cnt_eff >> k_ff;
   assign fval       = (cnt_eff == '0) ? '0 :
                       ((shifted == '0) ? COUNT_WIDTH'(1) : shifted);
   assign norm_eq    = (hi_w_ff[CODE_BITS-1] == lo_w_ff[CODE_BITS-1]);
   assign norm_uf    = lo_w_ff[CODE_BITS-2] && !hi_w_ff[CODE_BITS-2];
   assign hi_adj     = hi_w_ff | 16'h4000;
   assign lo_adj     = lo_w_ff & 16'h3FFF;
   assign enc_ok     = item_ff.in_range && (total_ff != '0) && (mdl_scaled != '0);

   // bit packer
   always_comb begin
      push_en  = 1'b0;
      push_val = 1'b0;
      unique case (state_ff)
         ST_NORM: begin
            push_en  = norm_eq;
            push_val = hi_w_ff[CODE_BITS-1];
         end
         ST_PEND: begin
            push_en  = 1'b1;
            push_val = pend_bit_ff;
         end
         ST_FIN1: begin
            push_en  = 1'b1;
            push_val = low_ff[CODE_BITS-2];
         end
         ST_FIN2: begin
            push_en  = 1'b1;
            push_val = !low_ff[CODE_BITS-2];
         end
         default: begin
         end
      endcase
   end

   assign pack_byte = partial_ff | (push_val ? (8'd1 << bitpos_ff) : 8'd0);
   assign pad_byte  = partial_ff | (8'hFF >> (3'd7 - bitpos_ff));
   assign emit_en   = (push_en && (bitpos_ff == 3'd0)) || (state_ff == ST_FIN_PAD);
   assign emit_data = (state_ff == ST_FIN_PAD) ? pad_byte : pack_byte;
   assign emit_keep = (n_ff < NW'(MAX_RESULTS - 1));
   assign step_ok   = !(emit_en && emit_keep && hold_vld_ff && !out_free);
   assign q_pop     = (state_ff == ST_IDLE) && q_valid;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               unique case (q_item.op)
                  OP_COUNT:  state_in = ST_FETCH;
                  OP_READ:   state_in = ST_FETCH;
                  OP_ENCODE: state_in = model_ready_ff ? ST_FETCH : ST_RB_SUM;
                  OP_FINISH: state_in = ST_FIN1;
               endcase
            end
         end
         ST_FETCH: begin
            unique case (item_ff.op)
               OP_COUNT:  state_in = ST_CNT_WR;
               OP_READ:   state_in = ST_RD_RESP;
               OP_ENCODE: state_in = ST_ENC_CHK;
               OP_FINISH: state_in = ST_IDLE;
            endcase
         end
         ST_CNT_WR:  state_in = ST_IDLE;
         ST_RD_RESP: if (out_free) state_in = ST_IDLE;
         ST_ENC_CHK: state_in = enc_ok ? ST_MUL_HI : ST_ERR;
         ST_ERR:     if (out_free) state_in = ST_IDLE;
         ST_MUL_HI:  state_in = ST_DIV_HI;
         ST_DIV_HI:  if (div_rsp.done) state_in = ST_MUL_LO;
         ST_MUL_LO:  state_in = ST_DIV_LO;
         ST_DIV_LO:  if (div_rsp.done) state_in = ST_NORM;
         ST_NORM: begin
            if (norm_eq) begin
               if (step_ok && (pending_ff != '0)) state_in = ST_PEND;
            end else if (!norm_uf) begin
               state_in = ST_DEC;
            end
         end
         ST_PEND: begin
            if (step_ok && (pending_ff == PW'(1))) begin
               state_in = (item_ff.op == OP_FINISH) ? ST_FIN_PAD : ST_NORM;
            end
         end
         ST_DEC:  state_in = ST_TAIL;
         ST_FIN1: if (step_ok) state_in = ST_FIN2;
         ST_FIN2: begin
            if (step_ok) state_in = (pending_ff != '0) ? ST_PEND : ST_FIN_PAD;
         end
         ST_FIN_PAD: if (step_ok) state_in = ST_TAIL;
         ST_TAIL: begin
            if (!hold_vld_ff || out_free) begin
               priority if (sat_ff) state_in = ST_SAT;
               else if (rb_post_ff) state_in = ST_RB_SUM;
               else state_in = ST_IDLE;
            end
         end
         ST_SAT: begin
            if (out_free) state_in = rb_post_ff ? ST_RB_SUM : ST_IDLE;
         end
         ST_RB_SUM: begin
            if (sw_end && ((sum_ff <= SW'(SCALE_LIMIT)) || (k_ff == KW'(COUNT_WIDTH)))) begin
               state_in = ST_RB_WR;
            end
         end
         ST_RB_WR: if (sw_end) state_in = rb_post_ff ? ST_IDLE : ST_FETCH;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      item_in        = item_ff;
      cnt_vld_in     = cnt_vld_ff;
      low_in         = low_ff;
      high_in        = high_ff;
      hi_w_in        = hi_w_ff;
      lo_w_in        = lo_w_ff;
      pending_in     = pending_ff;
      partial_in     = partial_ff;
      bitpos_in      = bitpos_ff;
      hold_vld_in    = hold_vld_ff;
      hold_byte_in   = hold_byte_ff;
      n_in           = n_ff;
      sat_in         = sat_ff;
      pend_bit_in    = pend_bit_ff;
      model_ready_in = model_ready_ff;
      total_in       = total_ff;
      rb_post_in     = rb_post_ff;
      k_in           = k_ff;
      sum_in         = sum_ff;
      acc_in         = acc_ff;
      sw_idx_in      = sw_idx_ff;
      sw_dv_in       = sw_dv_ff;
      sw_didx_in     = sw_didx_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_byte_in    = rsp_byte_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_status_in  = rsp_status_ff;
      cnt_we         = 1'b0;
      cnt_wa         = sym_idx;
      cnt_wd         = cnt_eff;
      mdl_we         = 1'b0;
      mdl_wa         = sw_didx_ff;
      mdl_wd         = {acc_ff, fval[SCALE_BITS-1:0]};
      div_req.start    = 1'b0;
      div_req.dividend = DIVIDEND_BITS'(range) * DIVIDEND_BITS'(mul_cum);
      div_req.divisor  = total_ff;
      push_go        = 1'b0;

      if (!rb_state) begin
         sw_idx_in = '0;
         sw_dv_in  = 1'b0;
         sum_in    = '0;
         acc_in    = '0;
         k_in      = '0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               item_in    = q_item;
               n_in       = '0;
               sat_in     = 1'b0;
               rb_post_in = 1'b0;
            end
         end
         ST_CNT_WR: begin
            if (item_ff.in_range && (cnt_eff != '1)) begin
               cnt_we = 1'b1;
               cnt_wd = cnt_eff + COUNT_WIDTH'(1);
            end
         end
         ST_RD_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = '0;
               rsp_count_in  = item_ff.in_range ? 32'(cnt_eff) : '0;
               rsp_last_in   = 1'b1;
               rsp_status_in = STATUS_OK;
            end
         end
         ST_ERR: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = '0;
               rsp_count_in  = '0;
               rsp_last_in   = 1'b1;
               rsp_status_in = STATUS_EMPTY;
            end
         end
         ST_MUL_HI: div_req.start = 1'b1;
         ST_DIV_HI: begin
            if (div_rsp.done) begin
               hi_w_in = low_ff + div_rsp.quotient[CODE_BITS-1:0] - CODE_BITS'(1);
            end
         end
         ST_MUL_LO: div_req.start = 1'b1;
         ST_DIV_LO: begin
            if (div_rsp.done) begin
               lo_w_in = low_ff + div_rsp.quotient[CODE_BITS-1:0];
            end
         end
         ST_NORM: begin
            if (norm_eq) begin
               if (step_ok) begin
                  push_go     = 1'b1;
                  pend_bit_in = !hi_w_ff[CODE_BITS-1];
                  hi_w_in     = {hi_w_ff[CODE_BITS-2:0], 1'b1};
                  lo_w_in     = {lo_w_ff[CODE_BITS-2:0], 1'b0};
               end
            end else if (norm_uf) begin
               if (pending_ff < PW'(UNDERFLOW_LIMIT)) begin
                  pending_in = pending_ff + PW'(1);
               end else begin
                  sat_in = 1'b1;
               end
               hi_w_in = {hi_adj[CODE_BITS-2:0], 1'b1};
               lo_w_in = {lo_adj[CODE_BITS-2:0], 1'b0};
            end else begin
               low_in  = lo_w_ff;
               high_in = hi_w_ff;
            end
         end
         ST_PEND: begin
            if (step_ok) begin
               push_go    = 1'b1;
               pending_in = pending_ff - PW'(1);
            end
         end
         ST_DEC: begin
            if (cnt_eff != '0) begin
               cnt_we     = 1'b1;
               cnt_wd     = cnt_eff - COUNT_WIDTH'(1);
               rb_post_in = (cnt_eff == COUNT_WIDTH'(1));
            end
         end
         ST_FIN1: push_go = step_ok;
         ST_FIN2: begin
            if (step_ok) begin
               push_go     = 1'b1;
               pend_bit_in = !low_ff[CODE_BITS-2];
            end
         end
         ST_FIN_PAD: push_go = step_ok;
         ST_TAIL: begin
            if (hold_vld_ff && out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = hold_byte_ff;
               rsp_count_in  = '0;
               rsp_last_in   = !sat_ff;
               rsp_status_in = STATUS_OK;
               hold_vld_in   = 1'b0;
            end
            // finish returns the coder and histogram to their reset state
            if ((!hold_vld_ff || out_free) && (item_ff.op == OP_FINISH)) begin
               cnt_vld_in     = '0;
               model_ready_in = 1'b0;
               total_in       = '0;
               low_in         = '0;
               high_in        = '1;
               pending_in     = '0;
               partial_in     = '0;
               bitpos_in      = 3'd7;
            end
         end
         ST_SAT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_byte_in   = '0;
               rsp_count_in  = '0;
               rsp_last_in   = 1'b1;
               rsp_status_in = STATUS_SAT;
            end
         end
         ST_RB_SUM: begin
            if (sw_dv_ff) begin
               sum_in = sum_ff + SW'(fval);
            end
            if (sw_end) begin
               sw_idx_in = '0;
               sum_in    = '0;
               if (sum_ff > SW'(SCALE_LIMIT)) begin
                  k_in = k_ff + KW'(1);
               end
            end
         end
         ST_RB_WR: begin
            if (sw_dv_ff) begin
               mdl_we = 1'b1;
               acc_in = acc_ff + fval[SCALE_BITS-1:0];
            end
            if (sw_end) begin
               total_in       = acc_ff;
               model_ready_in = 1'b1;
            end
         end
         default: begin
         end
      endcase

      // sweep read pipeline over the histogram
      if (rb_state && !sw_end) begin
         if (sw_issue) begin
            sw_idx_in  = sw_idx_ff + IW'(1);
            sw_dv_in   = 1'b1;
            sw_didx_in = sw_idx_ff[AW-1:0];
         end else begin
            sw_dv_in = 1'b0;
         end
      end

      if (push_go) begin
         if (emit_en) begin
            partial_in = '0;
            bitpos_in  = 3'd7;
            if (emit_keep) begin
               if (hold_vld_ff) begin
                  rsp_valid_in  = 1'b1;
                  rsp_byte_in   = hold_byte_ff;
                  rsp_count_in  = '0;
                  rsp_last_in   = 1'b0;
                  rsp_status_in = STATUS_OK;
               end
               hold_byte_in = emit_data;
               hold_vld_in  = 1'b1;
               n_in         = n_ff + NW'(1);
            end
         end else begin
            partial_in = pack_byte;
            bitpos_in  = bitpos_ff - 3'd1;
         end
      end

      if (cnt_we) begin
         cnt_vld_in[cnt_wa] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_vld_ff     <= '0;
         low_ff         <= '0;
         high_ff        <= '1;
         pending_ff     <= '0;
         partial_ff     <= '0;
         bitpos_ff      <= 3'd7;
         hold_vld_ff    <= 1'b0;
         sat_ff         <= 1'b0;
         model_ready_ff <= 1'b0;
         total_ff       <= '0;
         rb_post_ff     <= 1'b0;
         sw_idx_ff      <= '0;
         sw_dv_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cnt_vld_ff     <= cnt_vld_in;
         low_ff         <= low_in;
         high_ff        <= high_in;
         pending_ff     <= pending_in;
         partial_ff     <= partial_in;
         bitpos_ff      <= bitpos_in;
         hold_vld_ff    <= hold_vld_in;
         sat_ff         <= sat_in;
         model_ready_ff <= model_ready_in;
         total_ff       <= total_in;
         rb_post_ff     <= rb_post_in;
         sw_idx_ff      <= sw_idx_in;
         sw_dv_ff       <= sw_dv_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      hi_w_ff       <= hi_w_in;
      lo_w_ff       <= lo_w_in;
      hold_byte_ff  <= hold_byte_in;
      n_ff          <= n_in;
      pend_bit_ff   <= pend_bit_in;
      k_ff          <= k_in;
      sum_ff        <= sum_in;
      acc_ff        <= acc_in;
      sw_didx_ff    <= sw_didx_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   // histogram memory
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      cnt_rd_ff     <= cnt_mem[rd_addr];
      cnt_vld_rd_ff <= cnt_vld_ff[rd_addr];
   end

   // scaled model memory: {cumulative bound, scaled count}
   always_ff @(posedge clock) begin
      if (mdl_we) begin
         mdl_mem[mdl_wa] <= mdl_wd;
      end
      mdl_rd_ff <= mdl_mem[sym_idx];
   end

   acedm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_count_value = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_status      = rsp_status_ff;

`ifndef SYNTHESIS
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != STATUS_OK) |-> rsp_last_ff && (rsp_byte_ff == 8'd0))
      else $error("error request not final or carries data");

   a_pend_cap: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= PW'(UNDERFLOW_LIMIT))
      else $error("underflow counter beyond its limit");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !div_rsp.busy)
      else $error("divider busy while engine idle");
`endif

endmodule

[src/arithmetic_encoder_decrementing_model_unit.sv]
`timescale 1ns / 1ps
// Top level of the byte arithmetic encoder with a decrementing model.
// Encode item: the two interval bounds go through one serial divider.
// A model rebuild (first encode of a block, or a count running out) sweeps the
//   histogram, up to COUNT_WIDTH + 2 passes.
// Reset is synchronous; histogram valid bits clear at once, no clearing pass.
module arithmetic_encoder_decrementing_model_unit
   import acedm_pkg::*;
#(
   parameter int SYMBOL_COUNT    = SYMBOL_COUNT_DEF,
   parameter int COUNT_WIDTH     = COUNT_WIDTH_DEF,
   parameter int SCALE_LIMIT     = SCALE_LIMIT_DEF,
   parameter int UNDERFLOW_LIMIT = UNDERFLOW_LIMIT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [7:0]  req_symbol,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic [31:0] rsp_count_value,
   output logic        rsp_last,
   output logic [1:0]  rsp_status
);

   // front to back queue
   logic     q_valid;
   item_type q_item;
   logic     q_pop;

   // Front end decodes the kind, checks the symbol range and buffers up to
   // two requests so the host keeps streaming while the engine works.
   acedm_front #(
      .SYMBOL_COUNT (SYMBOL_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_kind   (req_kind),
      .req_symbol (req_symbol),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   // Engine owns the histogram, the scaled model memory and the coder.
   // Its result register decouples it from a stalled consumer; one coded
   // byte is held back so the final one can carry last.
   acedm_back #(
      .SYMBOL_COUNT    (SYMBOL_COUNT),
      .COUNT_WIDTH     (COUNT_WIDTH),
      .SCALE_LIMIT     (SCALE_LIMIT),
      .UNDERFLOW_LIMIT (UNDERFLOW_LIMIT)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_item          (q_item),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_count_value (rsp_count_value),
      .rsp_last        (rsp_last),
      .rsp_status      (rsp_status)
   );

endmodule
